[sv/zpca_pkg.sv]
// Shared types and constants of the zoom, pan and crop controller.
`default_nettype none

package zpca_pkg;

    // Field widths.
    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 8;
    localparam int ZOOM_BITS  = 11;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;

    // Normalized center in Q0.16, where one whole is 65536 and needs one more bit.
    localparam int CTR_FRAC = 16;
    localparam int CTR_BITS = CTR_FRAC + 1;
    localparam int CTR_ONE  = 1 << CTR_FRAC;
    localparam int CTR_HALF = 1 << (CTR_FRAC - 1);

    // Source size in fixed point and derived datapath widths.
    localparam int S_W    = COORD_BITS + FRAC_BITS;
    localparam int P_W    = S_W + CTR_BITS;
    localparam int DVS_W  = COORD_BITS;
    localparam int DIV_W  = (COORD_BITS + CTR_FRAC > S_W + 7) ?
                            (COORD_BITS + CTR_FRAC) : (S_W + 7);

    // Zoom constants in hundredths.
    localparam int ZOOM_ONE   = 100;
    localparam int ZOOM_SNAP  = 105;
    localparam int ZOOM_CLICK = 200;
    localparam int ZOOM_STEP  = 30;
    localparam int ZOOM_PCT   = 100;

    // Easing factor 38/256.
    localparam int EASE_NUM   = 38;
    localparam int EASE_SHIFT = 8;

    // Register reset values.
    localparam int RST_SRC_W    = 1920;
    localparam int RST_SRC_H    = 1080;
    localparam int RST_ZOOM_MAX = 500;
    localparam int RST_ZOOM_MIN = 100;

    typedef enum logic [1:0] {
        OP_CLICK  = 2'd0,
        OP_WHEEL  = 2'd1,
        OP_ESCAPE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_SRC_W    = 3'd1,
        CFG_SRC_H    = 3'd2,
        CFG_PRV_W    = 3'd3,
        CFG_PRV_H    = 3'd4,
        CFG_ZOOM_MAX = 3'd5,
        CFG_ZOOM_MIN = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        op_t                   operation;
        logic [COORD_BITS-1:0] pointer_x;
        logic [COORD_BITS-1:0] pointer_y;
        logic                  wheel_up;
    } in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] crop_left;
        logic [COORD_BITS-1:0] crop_right;
        logic [COORD_BITS-1:0] crop_top;
        logic [COORD_BITS-1:0] crop_bottom;
        logic [ZOOM_BITS-1:0]  zoom_level;
        logic                  consumed;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/zoom_pan_crop_animator.sv]
// Top level of the zoom, pan and crop controller: sequencer, state and config registers.
// One item is in work at a time, on one shared bit-serial divider; input is ready only when idle.
// Reset (aresetn low, synchronous) restores the register defaults, zoom 1.00, centered view,
// and zero target and eased crops.
`default_nettype none

module zoom_pan_crop_animator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire zpca_pkg::in_t                       s_data,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output zpca_pkg::out_t                           m_data,

    input  wire logic                                cfg_wr_en,
    input  wire logic [zpca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [zpca_pkg::CFG_W-1:0]          cfg_data
);

    localparam int COORD = zpca_pkg::COORD_BITS;
    localparam int FRAC  = zpca_pkg::FRAC_BITS;
    localparam int ZB    = zpca_pkg::ZOOM_BITS;
    localparam int ZW    = ZB + 1;
    localparam int CB    = zpca_pkg::CTR_BITS;
    localparam int SW    = zpca_pkg::S_W;
    localparam int PW    = zpca_pkg::P_W;
    localparam int DIV_W = zpca_pkg::DIV_W;
    localparam int DVS_W = zpca_pkg::DVS_W;
    localparam int LW    = SW + 2;
    localparam int ESH   = zpca_pkg::EASE_SHIFT;
    localparam int SUM_W = SW + ESH + 1;

    // The sequencer walks through the divider jobs, the multiply and the clamp, or
    // through the four easing updates, or goes straight on, and finally loads the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_CLAMP,
        ST_EASE_MUL,
        ST_EASE_UPD,
        ST_FINISH
    } state_t;

    // Which quotient the divider is working on.
    typedef enum logic [1:0] {
        JOB_NORM_X,
        JOB_NORM_Y,
        JOB_VIEW
    } job_t;

    state_t state_reg;
    job_t   job_reg;
    logic   axis_reg;
    logic [1:0] idx_reg;
    logic   consumed_reg;
    logic   m_valid_reg;

    // Configuration registers.
    logic             enable_reg;
    logic [COORD-1:0] src_w_reg;
    logic [COORD-1:0] src_h_reg;
    logic [COORD-1:0] prv_w_reg;
    logic [COORD-1:0] prv_h_reg;
    logic [ZB-1:0]    zoom_max_reg;
    logic [ZB-1:0]    zoom_min_reg;

    // Controller state.
    logic [ZB-1:0]    zoom_reg;
    logic [CB-1:0]    ctr_x_reg;
    logic [CB-1:0]    ctr_y_reg;
    logic [COORD-1:0] tgt_reg [4];
    logic [SW-1:0]    eased_reg [4];

    // Work registers of the datapath.
    logic [COORD-1:0] px_reg;
    logic [COORD-1:0] py_reg;
    logic [SW-1:0]    v_reg;
    logic [PW-1:0]    prod_reg;
    logic             neg_reg;
    zpca_pkg::out_t   m_data_reg;

    zpca_pkg::div_req_t div_req;
    zpca_pkg::div_rsp_t div_rsp;

    logic             in_accept;
    logic             out_load;
    zpca_pkg::op_t    op;

    logic [ZW-1:0]    z_up;
    logic [ZW-1:0]    z_up_c;
    logic [ZW-1:0]    z_dn;
    logic [ZW-1:0]    z_dn_c;
    logic [ZW-1:0]    z_new;
    logic             z_reset;
    logic             src_ok;

    logic [COORD-1:0] src_sel;
    logic [SW-1:0]    s_val;
    logic [CB-1:0]    ctr_sel;
    logic [COORD-1:0] ptr_sel;
    logic [COORD-1:0] prv_sel;
    logic [DIV_W-1:0] s_x100;
    logic [CB-1:0]    q_sat;

    logic [SW-1:0]    mul_a;
    logic [CB-1:0]    mul_b;
    logic [PW-1:0]    mul_p;

    logic [SW-1:0]       base;
    logic signed [LW-1:0] l_raw;
    logic signed [LW-1:0] top_s;
    logic signed [LW-1:0] l_sel;
    logic [SW-1:0]       l_c;
    logic [SW-1:0]       hi_full;
    logic [COORD-1:0]    crop_lo;
    logic [COORD-1:0]    crop_hi;

    logic [SW-1:0]    t_val;
    logic [SW-1:0]    e_val;
    logic [SW:0]      d_val;
    logic             d_neg;
    logic [SW-1:0]    mag;
    logic [SUM_W-1:0] step_sum;
    logic [SW-1:0]    step;
    logic [SW-1:0]    e_new;

    zpca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign op        = s_data.operation;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // The result register is loaded once the previous result has been taken.
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // Wheel step on the current zoom, kept one bit wider than the zoom field.
    always_comb begin
        z_up    = ZW'(zoom_reg) + ZW'(zpca_pkg::ZOOM_STEP);
        z_up_c  = (z_up > ZW'(zoom_max_reg)) ? ZW'(zoom_max_reg) : z_up;
        z_dn    = ZW'(zoom_reg) - ZW'(zpca_pkg::ZOOM_STEP);
        z_dn_c  = (z_dn < ZW'(zoom_min_reg)) ? ZW'(zoom_min_reg) : z_dn;
        z_new   = s_data.wheel_up ? z_up_c : z_dn_c;
        z_reset = (z_new <= ZW'(zpca_pkg::ZOOM_ONE));
    end

    // A zero source dimension leaves the target crops untouched.
    assign src_ok = (src_w_reg != '0) && (src_h_reg != '0);

    // Axis operands: source size in fixed point and the matching center.
    assign src_sel = axis_reg ? src_h_reg : src_w_reg;
    assign s_val   = {src_sel, {FRAC{1'b0}}};
    assign ctr_sel = axis_reg ? ctr_y_reg : ctr_x_reg;
    assign s_x100  = DIV_W'(s_val) * DIV_W'(zpca_pkg::ZOOM_PCT);

    // Divider operands. A zero preview dimension counts as one.
    assign ptr_sel = (job_reg == JOB_NORM_Y) ? py_reg : px_reg;
    assign prv_sel = (job_reg == JOB_NORM_Y) ? prv_h_reg : prv_w_reg;

    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        case (job_reg)
            JOB_NORM_X, JOB_NORM_Y: begin
                div_req.dividend = DIV_W'({ptr_sel, {zpca_pkg::CTR_FRAC{1'b0}}});
                div_req.divisor  = (prv_sel == '0) ? DVS_W'(1) : prv_sel;
            end
            JOB_VIEW: begin
                div_req.dividend = s_x100;
                div_req.divisor  = DVS_W'(zoom_reg);
            end
            default: begin
                div_req.dividend = '0;
                div_req.divisor  = DVS_W'(1);
            end
        endcase
    end

    // The normalized position saturates at one whole.
    assign q_sat = (div_rsp.quotient > DIV_W'(zpca_pkg::CTR_ONE)) ?
                   CB'(zpca_pkg::CTR_ONE) : div_rsp.quotient[CB-1:0];

    // One multiplier serves both the center scaling and the easing step.
    always_comb begin
        if (state_reg == ST_EASE_MUL) begin
            mul_a = mag;
            mul_b = CB'(zpca_pkg::EASE_NUM);
        end else begin
            mul_a = s_val;
            mul_b = ctr_sel;
        end
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Window placement: left edge is the scaled center minus half the visible size,
    // clamped so that the window stays inside the source.
    always_comb begin
        base  = prod_reg[zpca_pkg::CTR_FRAC +: SW];
        l_raw = $signed({2'b00, base}) - $signed({3'b000, v_reg[SW-1:1]});
        top_s = $signed({2'b00, s_val - v_reg});
        if (l_raw < 0) begin
            l_sel = '0;
        end else if (l_raw > top_s) begin
            l_sel = top_s;
        end else begin
            l_sel = l_raw;
        end
        l_c     = l_sel[SW-1:0];
        hi_full = s_val - l_c - v_reg;
        crop_lo = l_c[FRAC +: COORD];
        crop_hi = hi_full[FRAC +: COORD];
    end

    // Easing: move by ceil(|d| * 38 / 256) toward the target, which never overshoots.
    always_comb begin
        t_val    = {tgt_reg[idx_reg], {FRAC{1'b0}}};
        e_val    = eased_reg[idx_reg];
        d_val    = {1'b0, t_val} - {1'b0, e_val};
        d_neg    = d_val[SW];
        mag      = d_neg ? SW'(-d_val) : d_val[SW-1:0];
        step_sum = SUM_W'(prod_reg[SW+ESH-1:0]) + SUM_W'((1 << ESH) - 1);
        step     = step_sum[ESH +: SW];
        e_new    = neg_reg ? (e_val - step) : (e_val + step);
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            src_w_reg    <= COORD'(zpca_pkg::RST_SRC_W);
            src_h_reg    <= COORD'(zpca_pkg::RST_SRC_H);
            prv_w_reg    <= COORD'(zpca_pkg::RST_SRC_W);
            prv_h_reg    <= COORD'(zpca_pkg::RST_SRC_H);
            zoom_max_reg <= ZB'(zpca_pkg::RST_ZOOM_MAX);
            zoom_min_reg <= ZB'(zpca_pkg::RST_ZOOM_MIN);
        end else if (cfg_wr_en) begin
            case (zpca_pkg::cfg_idx_t'(cfg_index))
                zpca_pkg::CFG_ENABLE:   enable_reg   <= cfg_data[0];
                zpca_pkg::CFG_SRC_W:    src_w_reg    <= cfg_data[COORD-1:0];
                zpca_pkg::CFG_SRC_H:    src_h_reg    <= cfg_data[COORD-1:0];
                zpca_pkg::CFG_PRV_W:    prv_w_reg    <= cfg_data[COORD-1:0];
                zpca_pkg::CFG_PRV_H:    prv_h_reg    <= cfg_data[COORD-1:0];
                zpca_pkg::CFG_ZOOM_MAX: zoom_max_reg <= cfg_data[ZB-1:0];
                zpca_pkg::CFG_ZOOM_MIN: zoom_min_reg <= cfg_data[ZB-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer together with the controller state it updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            job_reg      <= JOB_NORM_X;
            axis_reg     <= 1'b0;
            idx_reg      <= '0;
            consumed_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            zoom_reg     <= ZB'(zpca_pkg::ZOOM_ONE);
            ctr_x_reg    <= CB'(zpca_pkg::CTR_HALF);
            ctr_y_reg    <= CB'(zpca_pkg::CTR_HALF);
            for (int i = 0; i < 4; i++) begin
                tgt_reg[i]   <= '0;
                eased_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        consumed_reg <= (op != zpca_pkg::OP_TICK) && enable_reg;
                        if (op == zpca_pkg::OP_TICK) begin
                            idx_reg   <= '0;
                            state_reg <= ST_EASE_MUL;
                        end else if (!enable_reg) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            case (op)
                                zpca_pkg::OP_CLICK: begin
                                    if (zoom_reg <= ZB'(zpca_pkg::ZOOM_SNAP)) begin
                                        zoom_reg <= ZB'(zpca_pkg::ZOOM_CLICK);
                                    end
                                    job_reg   <= JOB_NORM_X;
                                    state_reg <= ST_DIV_GO;
                                end
                                zpca_pkg::OP_WHEEL: begin
                                    if (z_reset) begin
                                        zoom_reg <= ZB'(zpca_pkg::ZOOM_ONE);
                                        for (int i = 0; i < 4; i++) begin
                                            tgt_reg[i] <= '0;
                                        end
                                        state_reg <= ST_FINISH;
                                    end else begin
                                        zoom_reg <= z_new[ZB-1:0];
                                        if (src_ok) begin
                                            job_reg   <= JOB_VIEW;
                                            axis_reg  <= 1'b0;
                                            state_reg <= ST_DIV_GO;
                                        end else begin
                                            state_reg <= ST_FINISH;
                                        end
                                    end
                                end
                                default: begin
                                    zoom_reg <= ZB'(zpca_pkg::ZOOM_ONE);
                                    for (int i = 0; i < 4; i++) begin
                                        tgt_reg[i] <= '0;
                                    end
                                    state_reg <= ST_FINISH;
                                end
                            endcase
                        end
                    end
                end

                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (job_reg)
                            JOB_NORM_X: begin
                                ctr_x_reg <= q_sat;
                                job_reg   <= JOB_NORM_Y;
                                state_reg <= ST_DIV_GO;
                            end
                            JOB_NORM_Y: begin
                                ctr_y_reg <= q_sat;
                                if (src_ok) begin
                                    job_reg   <= JOB_VIEW;
                                    axis_reg  <= 1'b0;
                                    state_reg <= ST_DIV_GO;
                                end else begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default: begin
                                state_reg <= ST_MUL;
                            end
                        endcase
                    end
                end

                ST_MUL: begin
                    state_reg <= ST_CLAMP;
                end

                ST_CLAMP: begin
                    tgt_reg[{axis_reg, 1'b0}] <= crop_lo;
                    tgt_reg[{axis_reg, 1'b1}] <= crop_hi;
                    if (!axis_reg) begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_DIV_GO;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_EASE_MUL: begin
                    state_reg <= ST_EASE_UPD;
                end

                ST_EASE_UPD: begin
                    eased_reg[idx_reg] <= e_new;
                    idx_reg            <= idx_reg + 2'd1;
                    state_reg          <= (idx_reg == 2'd3) ? ST_FINISH : ST_EASE_MUL;
                end

                ST_FINISH: begin
                    if (out_load) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath work registers and the result register; none of them needs a reset.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            px_reg <= s_data.pointer_x;
            py_reg <= s_data.pointer_y;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done && job_reg == JOB_VIEW) begin
            v_reg <= div_rsp.quotient[SW-1:0];
        end
        if (state_reg == ST_MUL || state_reg == ST_EASE_MUL) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_EASE_MUL) begin
            neg_reg <= d_neg;
        end
        if (out_load) begin
            m_data_reg.crop_left   <= eased_reg[0][FRAC +: COORD];
            m_data_reg.crop_right  <= eased_reg[1][FRAC +: COORD];
            m_data_reg.crop_top    <= eased_reg[2][FRAC +: COORD];
            m_data_reg.crop_bottom <= eased_reg[3][FRAC +: COORD];
            m_data_reg.zoom_level  <= zoom_reg;
            m_data_reg.consumed    <= consumed_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // A quotient must only arrive while the sequencer is waiting for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside of a wait state");

    // No new transfer is taken while the divider is still working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_rsp.busy)
        else $error("input ready while the divider is busy");

    // The target zoom never falls below 1.00.
    assert property (@(posedge aclk) disable iff (!aresetn)
        zoom_reg >= ZB'(zpca_pkg::ZOOM_ONE))
        else $error("target zoom below one");

    // An easing step never exceeds the remaining distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EASE_UPD) |-> (step <= mag))
        else $error("easing step overshoots the target");

    // A result appears only when the sequencer has finished an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid without a finished item");
`endif

endmodule

`default_nettype wire

[sv/zpca_div.sv]
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none

module zpca_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire zpca_pkg::div_req_t  req,
    output zpca_pkg::div_rsp_t       rsp
);

    localparam int DIV_W = zpca_pkg::DIV_W;
    localparam int DVS_W = zpca_pkg::DVS_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
